// File: sv/mact_pkg.sv
// Shared types, constants and codes of the moving average crossover trader.
package mact_pkg;

	// Default ring depth (largest window length)
	localparam int MAX_WINDOW_DEF = 256;

	// Register reset values
	localparam logic [8:0]  SHORT_WINDOW_RST = 9'd50;
	localparam logic [8:0]  LONG_WINDOW_RST  = 9'd200;
	localparam logic [31:0] CAPITAL_RST      = 32'd0;
	localparam logic [11:0] START_YEAR_RST   = 12'd0;
	localparam logic [11:0] END_YEAR_RST     = 12'd4095;

	// Money saturation limit
	localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

	// Serial arithmetic lengths
	localparam int MUL_STEPS = 32;
	localparam int DIV_BITS  = 80;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_SHORT_WINDOW = 3'd0,
		REG_LONG_WINDOW  = 3'd1,
		REG_CAPITAL      = 3'd2,
		REG_START_YEAR   = 3'd3,
		REG_END_YEAR     = 3'd4
	} reg_idx_t;

	// Relation of short average to long average
	typedef enum logic [1:0] {
		REL_LESS    = 2'd0,
		REL_EQUAL   = 2'd1,
		REL_GREATER = 2'd2
	} rel_t;

	// Trade reported with a result
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_BUY  = 2'd1,
		KIND_SELL = 2'd2
	} kind_t;

	// Multiplier operand choice
	typedef enum logic [1:0] {
		MS_SHORT = 2'd0,
		MS_LONG  = 2'd1,
		MS_VALUE = 2'd2
	} mul_sel_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_UPD, ST_DATE, ST_MA, ST_MB, ST_REL,
		ST_DIV, ST_SELL, ST_PVST, ST_PV, ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic     load_in;
		logic     ring_rd;
		logic     ring_upd;
		logic     date_step;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     cap_a;
		logic     cap_b;
		logic     cmp_upd;
		logic     div_start;
		logic     buy;
		logic     sell;
		logic     pv;
		logic     out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic finished;
		logic in_range;
		logic both_full;
		logic buy_go;
		logic sell_go;
		logic mul_done;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

// File: sv/mact_if.sv
// Channel interfaces: price samples in, results out, configuration writes.
interface mact_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] close_price;
	logic [11:0] year;
	logic [3:0]  month;
	modport source (output valid, close_price, year, month, input ready);
	modport sink (input valid, close_price, year, month, output ready);
endinterface

interface mact_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] portfolio_value;
	logic [47:0] cash_balance;
	logic [63:0] share_holding;
	logic [47:0] total_invested;
	logic [31:0] trade_count;
	logic [1:0]  trade_kind;
	logic        deposit_made;
	modport source (output valid, portfolio_value, cash_balance, share_holding,
		total_invested, trade_count, trade_kind, deposit_made, input ready);
	modport sink (input valid, portfolio_value, cash_balance, share_holding,
		total_invested, trade_count, trade_kind, deposit_made, output ready);
endinterface

interface mact_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/moving_average_crossover_trader.sv
// Top level of the moving average crossover trader.
// One daily close at a time: the close enters the short and long rings, then the date is
// checked, a deposit is made on a new month, and once both windows are full the averages
// are compared exactly as short_sum*long_len against long_sum*short_len, each product by a
// 32-step shift-add multiplier. A golden cross buys through an 80-step restoring divider, a
// death cross sells through one more multiply, and the portfolio value takes a last
// multiply. A sample that is out of range sends the controller back to idle after the
// date check with no result, and once the block has stopped a sample is dropped in idle.
// A new sample is taken only once the previous one has reached the result register,
// which holds it until the sink takes it. The rings hold no reset value and need no
// clearing pass. Configuration writes are taken in every cycle.
module moving_average_crossover_trader #(
	parameter int MAX_WINDOW = mact_pkg::MAX_WINDOW_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mact_in_if.sink    sample,
	mact_out_if.source result,
	mact_cfg_if.sink   cfg
);
	mact_pkg::cmd_t    cmd;
	mact_pkg::status_t st;

	assign cfg.ready = 1'b1;

	mact_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.st       (st),
		.cmd      (cmd)
	);

	mact_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.st                  (st),
		.in_close_price      (sample.close_price),
		.in_year             (sample.year),
		.in_month            (sample.month),
		.cfg_valid           (cfg.valid),
		.cfg_index           (cfg.index),
		.cfg_data            (cfg.data),
		.out_valid           (result.valid),
		.out_ready           (result.ready),
		.out_portfolio_value (result.portfolio_value),
		.out_cash_balance    (result.cash_balance),
		.out_share_holding   (result.share_holding),
		.out_total_invested  (result.total_invested),
		.out_trade_count     (result.trade_count),
		.out_trade_kind      (result.trade_kind),
		.out_deposit_made    (result.deposit_made)
	);
endmodule

// File: sv/mact_mul.sv
// Shift-add multiplier, 64 x 32 bits, one multiplier bit per cycle.
module mact_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [31:0] b,
	output logic [95:0] p,
	output logic        done
);
	localparam int CW = $clog2(mact_pkg::MUL_STEPS);

	logic [63:0]   a_q;
	logic [63:0]   hi_q;
	logic [31:0]   lo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [64:0]   sum;

	// add the multiplicand when the low multiplier bit is set
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 65'd0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(mact_pkg::MUL_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(mact_pkg::MUL_STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// product shift register
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[64:1];
			lo_q <= {sum[0], lo_q[31:1]};
		end
	end

	assign p    = {hi_q, lo_q};
	assign done = done_q;
endmodule

// File: sv/mact_div.sv
// Restoring divider: floor(cash * 2^32 / price), one quotient bit per cycle.
module mact_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] cash,
	input  logic [31:0] divisor,
	output logic [79:0] quot,
	output logic        done
);
	localparam int NB = mact_pkg::DIV_BITS;
	localparam int CW = $clog2(NB);

	logic [NB-1:0] q_q;
	logic [31:0]   rem_q;
	logic [31:0]   d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   trial;
	logic [32:0]   diff;
	logic          fits;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, q_q[NB-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = trial >= {1'b0, d_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(NB - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NB - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= {cash, 32'd0};
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : trial[31:0];
			q_q   <= {q_q[NB-2:0], fits};
		end
	end

	assign quot = q_q;
	assign done = done_q;
endmodule

// File: sv/mact_ctrl.sv
// Controller: sequences one sample through window, date, compare, trade and value steps.
module mact_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mact_pkg::status_t   st,
	output mact_pkg::cmd_t      cmd
);
	mact_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mact_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = mact_pkg::MS_VALUE;
		in_ready    = 1'b0;
		unique case (state_q)
			mact_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					// a stopped block swallows samples
					if (!st.finished)
						state_d = mact_pkg::ST_RD;
				end
			end
			mact_pkg::ST_RD: begin
				cmd.ring_rd = 1'b1;
				state_d     = mact_pkg::ST_UPD;
			end
			mact_pkg::ST_UPD: begin
				cmd.ring_upd = 1'b1;
				state_d      = mact_pkg::ST_DATE;
			end
			mact_pkg::ST_DATE: begin
				cmd.date_step = 1'b1;
				if (!st.in_range)
					state_d = mact_pkg::ST_IDLE;
				else if (st.both_full) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = mact_pkg::MS_SHORT;
					state_d       = mact_pkg::ST_MA;
				end else
					state_d = mact_pkg::ST_PVST;
			end
			mact_pkg::ST_MA: begin
				if (st.mul_done) begin
					cmd.cap_a     = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = mact_pkg::MS_LONG;
					state_d       = mact_pkg::ST_MB;
				end
			end
			mact_pkg::ST_MB: begin
				if (st.mul_done) begin
					cmd.cap_b = 1'b1;
					state_d   = mact_pkg::ST_REL;
				end
			end
			mact_pkg::ST_REL: begin
				cmd.cmp_upd = 1'b1;
				if (st.buy_go) begin
					cmd.div_start = 1'b1;
					state_d       = mact_pkg::ST_DIV;
				end else if (st.sell_go) begin
					cmd.mul_start = 1'b1;
					state_d       = mact_pkg::ST_SELL;
				end else begin
					cmd.mul_start = 1'b1;
					state_d       = mact_pkg::ST_PV;
				end
			end
			mact_pkg::ST_DIV: begin
				if (st.div_done) begin
					cmd.buy = 1'b1;
					state_d = mact_pkg::ST_PVST;
				end
			end
			mact_pkg::ST_SELL: begin
				if (st.mul_done) begin
					cmd.sell = 1'b1;
					state_d  = mact_pkg::ST_PVST;
				end
			end
			mact_pkg::ST_PVST: begin
				cmd.mul_start = 1'b1;
				state_d       = mact_pkg::ST_PV;
			end
			mact_pkg::ST_PV: begin
				if (st.mul_done) begin
					cmd.pv  = 1'b1;
					state_d = mact_pkg::ST_OUT;
				end
			end
			mact_pkg::ST_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = mact_pkg::ST_IDLE;
				end
			end
			default: state_d = mact_pkg::ST_IDLE;
		endcase
	end
endmodule

// File: sv/mact_dp.sv
// Datapath: window rings and sums, date tracking, portfolio registers, result register.
module mact_dp #(
	parameter int MAX_WINDOW = mact_pkg::MAX_WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mact_pkg::cmd_t    cmd,
	output mact_pkg::status_t st,
	input  logic [31:0]       in_close_price,
	input  logic [11:0]       in_year,
	input  logic [3:0]        in_month,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [47:0]       out_portfolio_value,
	output logic [47:0]       out_cash_balance,
	output logic [63:0]       out_share_holding,
	output logic [47:0]       out_total_invested,
	output logic [31:0]       out_trade_count,
	output logic [1:0]        out_trade_kind,
	output logic              out_deposit_made
);
	localparam int HW   = $clog2(MAX_WINDOW);
	localparam int LENW = $clog2(MAX_WINDOW + 1);
	localparam int SW   = 32 + LENW;

	// configuration
	logic [8:0]  short_w_q, long_w_q;
	logic [31:0] capital_q;
	logic [11:0] start_q, end_q;

	// sample
	logic [31:0] close_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;

	// windows
	logic [31:0]     short_ring [MAX_WINDOW];
	logic [31:0]     long_ring [MAX_WINDOW];
	logic [31:0]     short_old_q, long_old_q;
	logic [SW-1:0]   short_sum_q, long_sum_q;
	logic [LENW-1:0] short_fill_q, long_fill_q;
	logic [HW-1:0]   short_head_q, long_head_q;

	// trading state
	mact_pkg::rel_t  prev_rel_q, rel_q;
	logic            prev_valid_q;
	logic [47:0]     cash_q, invested_q, pv_q;
	logic [63:0]     shares_q;
	logic [31:0]     trades_q;
	logic [3:0]      last_month_q;
	logic [11:0]     last_year_q;
	logic            date_seen_q, finished_q;
	mact_pkg::kind_t kind_q;
	logic            dep_q;
	logic [63:0]     prod_a_q;
	logic            out_valid_q;

	// effective window lengths
	logic [31:0]     ls32, ll32;
	logic [LENW-1:0] ls, ll;
	always_comb begin
		ls32 = 32'(short_w_q);
		ll32 = 32'(long_w_q);
		if (ls32 == 32'd0) ls32 = 32'd1;
		else if (ls32 > 32'(MAX_WINDOW)) ls32 = 32'(MAX_WINDOW);
		if (ll32 == 32'd0) ll32 = 32'd1;
		else if (ll32 > 32'(MAX_WINDOW)) ll32 = 32'(MAX_WINDOW);
		ls = ls32[LENW-1:0];
		ll = ll32[LENW-1:0];
	end

	// ring slot and next head
	logic [HW-1:0]   sh, lh, sh_n, lh_n;
	logic [LENW-1:0] sh_inc, lh_inc;
	always_comb begin
		sh     = (LENW'(short_head_q) >= ls) ? '0 : short_head_q;
		lh     = (LENW'(long_head_q) >= ll) ? '0 : long_head_q;
		sh_inc = LENW'(sh) + 1'b1;
		lh_inc = LENW'(lh) + 1'b1;
		sh_n   = (sh_inc >= ls) ? '0 : sh_inc[HW-1:0];
		lh_n   = (lh_inc >= ll) ? '0 : lh_inc[HW-1:0];
	end

	// ring memories
	always_ff @(posedge clk) begin
		if (cmd.ring_rd) begin
			short_old_q <= short_ring[sh];
			long_old_q  <= long_ring[lh];
		end
		if (cmd.ring_upd) begin
			short_ring[sh] <= close_q;
			long_ring[lh]  <= close_q;
		end
	end

	// date decisions
	logic year_lo, year_hi, new_month;
	assign year_lo   = year_q < start_q;
	assign year_hi   = year_q > end_q;
	assign new_month = !date_seen_q || (month_q != last_month_q) || (year_q != last_year_q);

	// arithmetic units: the multiplier is shared, the divider serves the buy
	logic [63:0] mul_a;
	logic [31:0] mul_b;
	logic [95:0] mul_p;
	logic        mul_done;
	logic [79:0] div_q;
	logic        div_done;

	always_comb begin
		unique case (cmd.mul_sel)
			mact_pkg::MS_SHORT: begin
				mul_a = 64'(short_sum_q);
				mul_b = 32'(ll);
			end
			mact_pkg::MS_LONG: begin
				mul_a = 64'(long_sum_q);
				mul_b = 32'(ls);
			end
			default: begin
				mul_a = shares_q;
				mul_b = close_q;
			end
		endcase
	end

	mact_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.p      (mul_p),
		.done   (mul_done)
	);

	mact_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.cash    (cash_q),
		.divisor (close_q),
		.quot    (div_q),
		.done    (div_done)
	);

	// money arithmetic
	logic [48:0] dep_cash, dep_inv, sell_sum, pv_sum;
	logic [63:0] value, buy_add;
	logic [64:0] buy_sum;
	logic [47:0] sell_cash;
	logic [31:0] trades_n;
	always_comb begin
		value     = mul_p[95:32];
		dep_cash  = {1'b0, cash_q} + 49'(capital_q);
		dep_inv   = {1'b0, invested_q} + 49'(capital_q);
		sell_sum  = {1'b0, cash_q} + {1'b0, value[47:0]};
		pv_sum    = {1'b0, cash_q} + {1'b0, value[47:0]};
		buy_add   = (div_q[79:64] != 16'd0) ? '1 : div_q[63:0];
		buy_sum   = {1'b0, shares_q} + {1'b0, buy_add};
		sell_cash = (value[63:48] != 16'd0) ? mact_pkg::M48 :
			(sell_sum[48] ? mact_pkg::M48 : sell_sum[47:0]);
		trades_n  = (trades_q == '1) ? trades_q : trades_q + 1'b1;
	end

	// compare of cross-multiplied sums
	mact_pkg::rel_t rel_n;
	always_comb begin
		if (prod_a_q < mul_p[63:0]) rel_n = mact_pkg::REL_LESS;
		else if (prod_a_q > mul_p[63:0]) rel_n = mact_pkg::REL_GREATER;
		else rel_n = mact_pkg::REL_EQUAL;
	end

	// sample latch and operands
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			close_q <= in_close_price;
			year_q  <= in_year;
			month_q <= in_month;
		end
		if (cmd.cap_a) prod_a_q <= mul_p[63:0];
		if (cmd.cap_b) rel_q <= rel_n;
		if (cmd.pv)
			pv_q <= (value[63:48] != 16'd0) ? mact_pkg::M48 :
				(pv_sum[48] ? mact_pkg::M48 : pv_sum[47:0]);
	end

	// trader state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_w_q    <= mact_pkg::SHORT_WINDOW_RST;
			long_w_q     <= mact_pkg::LONG_WINDOW_RST;
			capital_q    <= mact_pkg::CAPITAL_RST;
			start_q      <= mact_pkg::START_YEAR_RST;
			end_q        <= mact_pkg::END_YEAR_RST;
			short_sum_q  <= '0;
			long_sum_q   <= '0;
			short_fill_q <= '0;
			long_fill_q  <= '0;
			short_head_q <= '0;
			long_head_q  <= '0;
			prev_rel_q   <= mact_pkg::REL_EQUAL;
			prev_valid_q <= 1'b0;
			cash_q       <= '0;
			shares_q     <= '0;
			invested_q   <= '0;
			trades_q     <= '0;
			last_month_q <= '0;
			last_year_q  <= '0;
			date_seen_q  <= 1'b0;
			finished_q   <= 1'b0;
			kind_q       <= mact_pkg::KIND_NONE;
			dep_q        <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				kind_q <= mact_pkg::KIND_NONE;
				dep_q  <= 1'b0;
			end
			// push the close into both windows
			if (cmd.ring_upd) begin
				if (short_fill_q < ls) begin
					short_fill_q <= short_fill_q + 1'b1;
					short_sum_q  <= short_sum_q + SW'(close_q);
				end else
					short_sum_q <= short_sum_q - SW'(short_old_q) + SW'(close_q);
				if (long_fill_q < ll) begin
					long_fill_q <= long_fill_q + 1'b1;
					long_sum_q  <= long_sum_q + SW'(close_q);
				end else
					long_sum_q <= long_sum_q - SW'(long_old_q) + SW'(close_q);
				short_head_q <= sh_n;
				long_head_q  <= lh_n;
			end
			// date range and monthly deposit
			if (cmd.date_step) begin
				if (year_lo) begin
					last_month_q <= month_q;
					last_year_q  <= year_q;
					date_seen_q  <= 1'b1;
				end else if (year_hi)
					finished_q <= 1'b1;
				else if (new_month) begin
					cash_q       <= dep_cash[48] ? mact_pkg::M48 : dep_cash[47:0];
					invested_q   <= dep_inv[48] ? mact_pkg::M48 : dep_inv[47:0];
					last_month_q <= month_q;
					last_year_q  <= year_q;
					date_seen_q  <= 1'b1;
					dep_q        <= 1'b1;
				end
			end
			if (cmd.cmp_upd) begin
				prev_rel_q   <= rel_q;
				prev_valid_q <= 1'b1;
			end
			// golden cross: all cash into shares
			if (cmd.buy) begin
				shares_q <= buy_sum[64] ? '1 : buy_sum[63:0];
				cash_q   <= '0;
				trades_q <= trades_n;
				kind_q   <= mact_pkg::KIND_BUY;
			end
			// death cross: all shares into cash
			if (cmd.sell) begin
				cash_q   <= sell_cash;
				shares_q <= '0;
				trades_q <= trades_n;
				kind_q   <= mact_pkg::KIND_SELL;
			end
			// register writes; a window write empties that window
			if (cfg_valid) begin
				unique case (cfg_index)
					mact_pkg::REG_SHORT_WINDOW: begin
						short_w_q    <= cfg_data[8:0];
						short_sum_q  <= '0;
						short_fill_q <= '0;
						short_head_q <= '0;
						prev_valid_q <= 1'b0;
					end
					mact_pkg::REG_LONG_WINDOW: begin
						long_w_q     <= cfg_data[8:0];
						long_sum_q   <= '0;
						long_fill_q  <= '0;
						long_head_q  <= '0;
						prev_valid_q <= 1'b0;
					end
					mact_pkg::REG_CAPITAL:    capital_q <= cfg_data;
					mact_pkg::REG_START_YEAR: start_q   <= cfg_data[11:0];
					mact_pkg::REG_END_YEAR:   end_q     <= cfg_data[11:0];
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_portfolio_value <= pv_q;
			out_cash_balance    <= cash_q;
			out_share_holding   <= shares_q;
			out_total_invested  <= invested_q;
			out_trade_count     <= trades_q;
			out_trade_kind      <= kind_q;
			out_deposit_made    <= dep_q;
		end
	end

	assign out_valid = out_valid_q;

	// status to controller
	always_comb begin
		st.finished  = finished_q;
		st.in_range  = !year_lo && !year_hi;
		st.both_full = (short_fill_q >= ls) && (long_fill_q >= ll);
		st.buy_go    = prev_valid_q && (prev_rel_q == mact_pkg::REL_LESS) &&
			(rel_q == mact_pkg::REL_GREATER) && (close_q != 32'd0);
		st.sell_go   = prev_valid_q && (prev_rel_q == mact_pkg::REL_GREATER) &&
			(rel_q == mact_pkg::REL_LESS);
		st.mul_done  = mul_done;
		st.div_done  = div_done;
		st.out_free  = !out_valid_q || out_ready;
	end
endmodule

// File: sv/mact_checker.sv
// Port-level checks on the trader's result channel, bound to the top level.
module mact_props (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [47:0] pv,
	input logic [47:0] cash,
	input logic [63:0] shares,
	input logic [1:0]  kind
);
	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(pv) && $stable(shares))
		else $error("result word changed while stalled");

	// a buy spends all cash
	a_buy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == mact_pkg::KIND_BUY |-> cash == 48'd0)
		else $error("cash left after buy");

	// a sell empties the holding
	a_sell: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == mact_pkg::KIND_SELL |-> shares == 64'd0)
		else $error("shares left after sell");

	// value never below cash
	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pv >= cash)
		else $error("portfolio value below cash");
endmodule

bind moving_average_crossover_trader mact_props u_mact_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.pv        (result.portfolio_value),
	.cash      (result.cash_balance),
	.shares    (result.share_holding),
	.kind      (result.trade_kind)
);
